/* design/tfm_pkg.sv */
package tfm_pkg;

	// filter storage
	localparam int unsigned MaxFilterBytes = 32;
	localparam int unsigned FidxW          = $clog2(MaxFilterBytes + 1);
	localparam int unsigned FposW          = FidxW + 1;

	// queue between front and back
	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw    = $clog2(QDepth);

	// special characters
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NONE  = 8'h00;

	// configuration register indexes
	localparam logic [2:0] CFG_FB_0_7   = 3'd0;
	localparam logic [2:0] CFG_FB_8_15  = 3'd1;
	localparam logic [2:0] CFG_FB_16_23 = 3'd2;
	localparam logic [2:0] CFG_FB_24_31 = 3'd3;
	localparam logic [2:0] CFG_LEN      = 3'd4;

	typedef logic [MaxFilterBytes-1:0][7:0] filter_t;

	// classified item: tv is zero for an end of topic
	typedef struct packed {
		logic       last;
		logic [7:0] tv;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// filter byte at a position, zero past the valid length
	function automatic logic [7:0] filter_char(
		input filter_t          filt,
		input logic [5:0]       flen,
		input logic [FposW-1:0] pos
	);
		logic [FposW-1:0] len;
		begin
			len = FposW'(flen);
			if (len > FposW'(MaxFilterBytes))
				len = FposW'(MaxFilterBytes);
			if (pos >= len)
				filter_char = CH_NONE;
			else
				filter_char = filt[pos[$clog2(MaxFilterBytes)-1:0]];
		end
	endfunction

endpackage

/* design/topic_filter_match.sv */
// Topic filter matcher.
// Input channel (in_valid / in_stall): one topic character per transfer in
// topic_byte; a transfer with topic_end high closes the topic and carries no
// character. A zero character before the end stops matching early.
// Output channel (out_valid / out_stall): one is_match per closed topic,
// high when the topic matches the stored filter ('+' and '#' wildcards).
// Configuration: cfg_we writes cfg_data to register cfg_index: indexes 0..3
// hold filter bytes 0..31 (lowest byte first), index 4 the filter length.
// Write only while no topic is in flight.
// Throughput: one character per cycle while in_stall is low. The front register
// accepts while the back end works; a four-entry queue separates them.
// Result path: an end transfer passes the front register and the queue
// and sets out_valid when the output is free. A held output stalls only
// end items; characters flow until the queue fills, then in_stall rises.
// Reset: clears the filter, the length, the queue and the match state;
// out_valid is low after reset.
module topic_filter_match (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  topic_byte,
	input  logic        topic_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_match,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [3:0][63:0]        fwords_q;
	logic [5:0]              flen_q;
	tfm_pkg::filter_t        filt;
	tfm_pkg::q_stat_t        q_stat;
	tfm_pkg::item_t          push_item;
	tfm_pkg::item_t          head;
	logic                    push;
	logic                    pop;

	assign filt = tfm_pkg::filter_t'(fwords_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwords_q <= '0;
			flen_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tfm_pkg::CFG_FB_0_7:   fwords_q[0] <= cfg_data;
				tfm_pkg::CFG_FB_8_15:  fwords_q[1] <= cfg_data;
				tfm_pkg::CFG_FB_16_23: fwords_q[2] <= cfg_data;
				tfm_pkg::CFG_FB_24_31: fwords_q[3] <= cfg_data;
				tfm_pkg::CFG_LEN:      flen_q      <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	tfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.topic_byte (topic_byte),
		.topic_end  (topic_end),
		.q_stat     (q_stat),
		.push       (push),
		.push_item  (push_item)
	);

	tfm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	tfm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.filt      (filt),
		.flen      (flen_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_match  (is_match)
	);

	// the queue never takes a transfer while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("queue push while full");

	// the back end never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("queue pop while empty");

	// a new result appears only after an end item left the queue
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop && head.last))
		else $error("result without end item");

	// input stalls only when the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stall without full queue");

endmodule

/* design/tfm_front.sv */
module tfm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     topic_byte,
	input  logic           topic_end,
	input  tfm_pkg::q_stat_t q_stat,
	output logic           push,
	output tfm_pkg::item_t push_item
);

	logic           valid_s1;
	tfm_pkg::item_t item_s1;
	logic           accept;

	// hold the item only while the queue is full
	assign in_stall  = valid_s1 && q_stat.full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_stat.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify: an end item carries a zero character
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.last <= topic_end;
			item_s1.tv   <= topic_end ? tfm_pkg::CH_NONE : topic_byte;
		end
	end

endmodule

/* design/tfm_queue.sv */
module tfm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tfm_pkg::item_t   push_item,
	input  logic             pop,
	output tfm_pkg::item_t   head,
	output tfm_pkg::q_stat_t q_stat
);

	tfm_pkg::item_t             mem_q [tfm_pkg::QDepth];
	logic [tfm_pkg::QAw-1:0]    wr_ptr_q;
	logic [tfm_pkg::QAw-1:0]    rd_ptr_q;
	logic [tfm_pkg::QAw:0]      count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == (tfm_pkg::QAw+1)'(tfm_pkg::QDepth));
	assign head         = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

/* design/tfm_back.sv */
module tfm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tfm_pkg::filter_t filt,
	input  logic [5:0]       flen,
	input  tfm_pkg::item_t   head,
	input  tfm_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             is_match
);

	logic [tfm_pkg::FidxW-1:0] fidx_q;
	logic                      skip_q;
	logic                      fixed_q;
	logic                      outc_q;
	logic [7:0]                prev_q;
	logic                      out_valid_q;
	logic                      is_match_q;

	logic [tfm_pkg::FidxW-1:0] fidx_d;
	logic                      skip_d;
	logic                      fixed_d;
	logic                      outc_d;
	logic [7:0]                prev_d;
	logic                      go_skip;
	logic [7:0]                c_cur;
	logic [7:0]                c_nxt;
	logic [7:0]                c_skip;
	logic [7:0]                tv;
	logic                      out_free;

	assign out_valid = out_valid_q;
	assign is_match  = is_match_q;
	assign tv        = head.tv;

	// an end item needs the output slot, other items never wait
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !q_stat.empty && (!head.last || out_free);

	assign c_cur = tfm_pkg::filter_char(filt, flen, tfm_pkg::FposW'(fidx_q));
	assign c_nxt = tfm_pkg::filter_char(filt, flen, tfm_pkg::FposW'(fidx_q) + 1'b1);

	// match step for one character
	always_comb begin
		fidx_d  = fidx_q;
		skip_d  = skip_q;
		fixed_d = fixed_q;
		outc_d  = outc_q;
		prev_d  = prev_q;
		go_skip = 1'b0;
		c_skip  = skip_q ? c_cur : c_nxt;
		if (!fixed_q) begin
			if (!skip_q) begin
				if (c_cur == tfm_pkg::CH_NONE) begin
					fixed_d = 1'b1;
					outc_d  = (tv == tfm_pkg::CH_NONE);
				end else if (c_cur == tfm_pkg::CH_HASH) begin
					fixed_d = 1'b1;
					outc_d  = (c_nxt == tfm_pkg::CH_NONE) &&
						(prev_q == tfm_pkg::CH_NONE || prev_q == tfm_pkg::CH_SLASH);
				end else if (c_cur == tfm_pkg::CH_PLUS) begin
					if ((prev_q != tfm_pkg::CH_NONE && prev_q != tfm_pkg::CH_SLASH) ||
						(c_nxt != tfm_pkg::CH_SLASH && c_nxt != tfm_pkg::CH_NONE)) begin
						fixed_d = 1'b1;
						outc_d  = 1'b0;
					end else begin
						fidx_d  = fidx_q + 1'b1;
						skip_d  = 1'b1;
						go_skip = 1'b1;
					end
				end else if (c_cur != tv) begin
					fixed_d = 1'b1;
					outc_d  = 1'b0;
				end else begin
					prev_d = c_cur;
					fidx_d = fidx_q + 1'b1;
				end
			end else begin
				go_skip = 1'b1;
			end
			// inside a '+' level: wait for the closing separator or the topic end
			if (go_skip) begin
				if (tv == tfm_pkg::CH_SLASH) begin
					if (c_skip != tfm_pkg::CH_SLASH) begin
						fixed_d = 1'b1;
						outc_d  = 1'b0;
					end else begin
						prev_d = tfm_pkg::CH_SLASH;
						fidx_d = fidx_d + 1'b1;
						skip_d = 1'b0;
					end
				end else if (tv == tfm_pkg::CH_NONE) begin
					fixed_d = 1'b1;
					outc_d  = 1'b1;
				end
			end
		end
	end

	// matcher state, re-armed after each end item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q  <= '0;
			skip_q  <= 1'b0;
			fixed_q <= 1'b0;
			outc_q  <= 1'b0;
			prev_q  <= tfm_pkg::CH_NONE;
		end else if (pop) begin
			if (head.last) begin
				fidx_q  <= '0;
				skip_q  <= 1'b0;
				fixed_q <= 1'b0;
				outc_q  <= 1'b0;
				prev_q  <= tfm_pkg::CH_NONE;
			end else begin
				fidx_q  <= fidx_d;
				skip_q  <= skip_d;
				fixed_q <= fixed_d;
				outc_q  <= outc_d;
				prev_q  <= prev_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last)
			is_match_q <= fixed_d && outc_d;
	end

endmodule
